/* hdl/assert_macros.svh */
// Assertion macros shared by the slot allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge out of reset
`define SPA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication
`define SPA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define SPA_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SPA_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

/* hdl/spa_pkg.sv */
// Package: shared types and codes for the slot allocator.
package spa_pkg;

    // Fixed field widths of the request and response items
    localparam int FUNC_W   = 1;
    localparam int PAGE_W   = 3;
    localparam int SLOT_W   = 7;
    localparam int STATUS_W = 2;
    localparam int USED_W   = 8;

    // Request operations
    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 1'b1;

    // Response status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_BUSY = 2'd2;

    // Control sequencer states
    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } spa_state_t;

endpackage

/* hdl/pooled_slot_allocator_unit.sv */
// Top level of the pooled slot allocator.
//
// Request channel (req_valid / req_stall, fields func, page_in, slot_in):
// func selects allocate or free; page_in and slot_in name the slot to free.
// Response channel (rsp_valid / rsp_stall, fields status, page_out,
// slot_out, page_used): exactly one item per request, in request order.
// For each request the page row (busy bits and count) is read from a
// synchronous memory on acceptance; then, once the output register is free,
// the slot is picked, the row written back and the response registered.
// A new request is accepted only once the previous response is registered.
// Allocation picks the first page whose full flag is clear and the lowest
// free slot of that page through a carry-chain search over the row.
// Reset clears the page full flags and the row written flags, so every slot
// reads free with no clearing pass. If rsp_stall holds a response, the next
// request is still accepted and its row read, but its write-back and result
// wait until the output register frees; req_stall stays high meanwhile.
`include "assert_macros.svh"

module pooled_slot_allocator_unit #(
    parameter int SLOTS_PER_PAGE = 128,
    parameter int NUM_PAGES      = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [spa_pkg::FUNC_W-1:0]    func,
    input  logic [spa_pkg::PAGE_W-1:0]    page_in,
    input  logic [spa_pkg::SLOT_W-1:0]    slot_in,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [spa_pkg::STATUS_W-1:0]  status,
    output logic [spa_pkg::PAGE_W-1:0]    page_out,
    output logic [spa_pkg::SLOT_W-1:0]    slot_out,
    output logic [spa_pkg::USED_W-1:0]    page_used
);
    import spa_pkg::*;

    localparam int PW    = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int SW    = (SLOTS_PER_PAGE > 1) ? $clog2(SLOTS_PER_PAGE) : 1;
    localparam int CW    = $clog2(SLOTS_PER_PAGE + 1);
    localparam int ROW_W = SLOTS_PER_PAGE + CW;

    // Sequencer and request registers
    spa_state_t              state_reg, state_next;
    logic [FUNC_W-1:0]       func_reg;
    logic [PAGE_W-1:0]       page_reg;
    logic [SLOT_W-1:0]       slot_reg;
    logic [PW-1:0]           sel_page_reg;
    logic                    pool_full_reg;
    logic [NUM_PAGES-1:0]    page_full_reg, page_full_next;

    // Response registers
    logic                    rsp_valid_reg;
    logic [STATUS_W-1:0]     status_reg, status_next;
    logic [PAGE_W-1:0]       page_out_reg, page_out_next;
    logic [SLOT_W-1:0]       slot_out_reg, slot_out_next;
    logic [USED_W-1:0]       page_used_reg, page_used_next;

    // Memory and search signals
    logic                    accept;
    logic                    done;
    logic                    rd_en;
    logic [PW-1:0]           rd_addr;
    logic [ROW_W-1:0]        rd_row;
    logic                    wr_en;
    logic                    do_write;
    logic [ROW_W-1:0]        wr_row;
    logic [SLOTS_PER_PAGE-1:0] row_map;
    logic [CW-1:0]           row_cnt;
    logic [CW-1:0]           cnt_new;
    logic [SLOTS_PER_PAGE-1:0] map_new;
    logic                    page_found;
    logic [PW-1:0]           page_idx;
    logic [NUM_PAGES-1:0]    page_onehot;
    logic                    slot_found;
    logic [SW-1:0]           slot_idx;
    logic [SLOTS_PER_PAGE-1:0] slot_onehot;
    logic [SW-1:0]           free_idx;
    logic                    page_bad;
    logic                    slot_bad;

    // First page that still has room
    spa_slot_find #(
        .WIDTH (NUM_PAGES)
    ) u_page_find (
        .busy   (page_full_reg),
        .found  (page_found),
        .idx    (page_idx),
        .onehot (page_onehot)
    );

    // Page rows: busy map plus busy count
    spa_row_mem #(
        .DEPTH (NUM_PAGES),
        .WIDTH (ROW_W)
    ) u_row_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_row),
        .wr_en   (wr_en),
        .wr_addr (sel_page_reg),
        .wr_data (wr_row)
    );

    assign row_map = rd_row[SLOTS_PER_PAGE-1:0];
    assign row_cnt = rd_row[ROW_W-1:SLOTS_PER_PAGE];

    // Lowest free slot of the fetched row
    spa_slot_find #(
        .WIDTH (SLOTS_PER_PAGE)
    ) u_slot_find (
        .busy   (row_map),
        .found  (slot_found),
        .idx    (slot_idx),
        .onehot (slot_onehot)
    );

    // Handle range checks on free
    assign page_bad = 32'(page_reg) >= 32'(NUM_PAGES);
    assign slot_bad = 32'(slot_reg) >= 32'(SLOTS_PER_PAGE);
    assign free_idx = SW'(slot_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        req_stall = 1'b1;
        rd_en     = 1'b0;
        done      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                rd_en     = req_valid;
            end
            ST_RUN:
            begin
                done = !rsp_valid_reg || !rsp_stall;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    assign accept  = req_valid && !req_stall;
    assign rd_addr = (func == FUNC_ALLOC) ? page_idx : PW'(page_in);
    assign wr_en   = done && do_write;
    assign wr_row  = {cnt_new, map_new};

    // Modify step: result and new row
    always_comb
    begin
        do_write       = 1'b0;
        map_new        = row_map;
        cnt_new        = row_cnt;
        page_full_next = page_full_reg;
        status_next    = STATUS_OK;
        page_out_next  = page_reg;
        slot_out_next  = slot_reg;
        page_used_next = '0;
        if (func_reg == FUNC_ALLOC)
        begin
            if (pool_full_reg || !slot_found)
            begin
                status_next   = STATUS_FULL;
                page_out_next = '0;
                slot_out_next = '0;
            end
            else
            begin
                do_write       = 1'b1;
                map_new        = row_map | slot_onehot;
                cnt_new        = row_cnt + CW'(1);
                page_out_next  = PAGE_W'(sel_page_reg);
                slot_out_next  = SLOT_W'(slot_idx);
                page_used_next = USED_W'(cnt_new);
                if (32'(cnt_new) == 32'(SLOTS_PER_PAGE))
                begin
                    page_full_next[sel_page_reg] = 1'b1;
                end
            end
        end
        else
        begin
            if (page_bad)
            begin
                status_next = STATUS_NOT_BUSY;
            end
            else if (slot_bad || !row_map[free_idx])
            begin
                status_next    = STATUS_NOT_BUSY;
                page_used_next = USED_W'(row_cnt);
            end
            else
            begin
                do_write = 1'b1;
                map_new  = row_map & ~(SLOTS_PER_PAGE'(1) << free_idx);
                if (row_cnt != '0)
                begin
                    cnt_new = row_cnt - CW'(1);
                end
                page_used_next               = USED_W'(cnt_new);
                page_full_next[sel_page_reg] = 1'b0;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            page_full_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (wr_en)
            begin
                page_full_reg <= page_full_next;
            end
            if (done)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Request capture and response payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg      <= func;
            page_reg      <= page_in;
            slot_reg      <= slot_in;
            sel_page_reg  <= rd_addr;
            pool_full_reg <= !page_found;
        end
        if (done)
        begin
            status_reg    <= status_next;
            page_out_reg  <= page_out_next;
            slot_out_reg  <= slot_out_next;
            page_used_reg <= page_used_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign status    = status_reg;
    assign page_out  = page_out_reg;
    assign slot_out  = slot_out_reg;
    assign page_used = page_used_reg;

    // Checks
    `SPA_ASSERT_NXT(a_accept_runs, clk, rst_n, accept, state_reg == ST_RUN)
    `SPA_ASSERT_IMP(a_write_with_result, clk, rst_n, wr_en, done && status_next == STATUS_OK)
    `SPA_ASSERT_IMP(a_alloc_ok_used, clk, rst_n, done && func_reg == FUNC_ALLOC && status_next == STATUS_OK, page_used_next != '0)
    `SPA_ASSERT_NXT(a_done_gives_rsp, clk, rst_n, done, rsp_valid && state_reg == ST_IDLE)

endmodule

/* hdl/spa_row_mem.sv */
// Page row memory: one word per page, registered read, rows read as zero until written.
module spa_row_mem #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 136
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                     rd_data,
    input  logic                                 wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                     wr_data
);
    import spa_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] row_valid_reg;
    logic [WIDTH-1:0] rd_data_reg;
    logic             rd_valid_reg;

    // Storage array, no reset
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Per-row written flags, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    // Unwritten rows read as all free, count zero
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

/* hdl/spa_slot_find.sv */
// Lowest-zero finder: locates the first clear bit of a busy vector.
module spa_slot_find #(
    parameter int WIDTH = 128
) (
    input  logic [WIDTH-1:0]                         busy,
    output logic                                     found,
    output logic [(WIDTH > 1 ? $clog2(WIDTH) : 1)-1:0] idx,
    output logic [WIDTH-1:0]                         onehot
);
    import spa_pkg::*;

    localparam int IW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    // Carry of busy+1 stops at the first zero bit
    assign onehot = ~busy & (busy + WIDTH'(1));
    assign found  = |onehot;

    // One-hot to binary
    always_comb
    begin
        idx = '0;
        for (int i = 0; i < WIDTH; i++)
        begin
            if (onehot[i])
            begin
                idx = idx | IW'(i);
            end
        end
    end

endmodule

/* tb/pooled_slot_allocator_unit_test.sv */
// Self-checking testbench for the pooled slot allocator: directed rows, then random traffic.
`timescale 1ns / 1ps

module pooled_slot_allocator_unit_test;
    import spa_pkg::*;

    localparam int SLOTS = 128;
    localparam int PAGES = 8;

    // One response item
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PAGE_W-1:0]   page;
        logic [SLOT_W-1:0]   slot;
        logic [USED_W-1:0]   used;
    } slot_reply_t;

    // One directed row: request fields, and the reply when it is typed in
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [PAGE_W-1:0] page;
        logic [SLOT_W-1:0] slot;
        logic              typed;
        slot_reply_t       want;
    } pool_row_t;

    localparam int ROWS = 22;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_stall;
    logic [FUNC_W-1:0]   func      = FUNC_ALLOC;
    logic [PAGE_W-1:0]   page_in   = '0;
    logic [SLOT_W-1:0]   slot_in   = '0;
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   page_out;
    logic [SLOT_W-1:0]   slot_out;
    logic [USED_W-1:0]   page_used;

    // Predicted pool contents
    logic [SLOTS-1:0] pool_busy [PAGES];
    int unsigned      pool_count [PAGES];
    int unsigned      pool_hint [PAGES];
    int               pool_total;

    slot_reply_t owed_results[$];
    int          mismatches = 0;

    // Directed rows; untyped rows are checked against the predictor
    pool_row_t pool_rows [ROWS] = '{
        '{FUNC_ALLOC, 3'd0, 7'd0,   1'b1, '{STATUS_OK,       3'd0, 7'd0,   8'd1}},
        '{FUNC_ALLOC, 3'd7, 7'd127, 1'b1, '{STATUS_OK,       3'd0, 7'd1,   8'd2}},
        '{FUNC_ALLOC, 3'd0, 7'd0,   1'b1, '{STATUS_OK,       3'd0, 7'd2,   8'd3}},
        '{FUNC_FREE,  3'd0, 7'd1,   1'b1, '{STATUS_OK,       3'd0, 7'd1,   8'd2}},
        '{FUNC_FREE,  3'd0, 7'd1,   1'b1, '{STATUS_NOT_BUSY, 3'd0, 7'd1,   8'd2}},
        '{FUNC_ALLOC, 3'd5, 7'd85,  1'b1, '{STATUS_OK,       3'd0, 7'd1,   8'd3}},
        '{FUNC_FREE,  3'd7, 7'd127, 1'b1, '{STATUS_NOT_BUSY, 3'd7, 7'd127, 8'd0}},
        '{FUNC_FREE,  3'd0, 7'd127, 1'b1, '{STATUS_NOT_BUSY, 3'd0, 7'd127, 8'd3}},
        '{FUNC_FREE,  3'd7, 7'd0,   1'b1, '{STATUS_NOT_BUSY, 3'd7, 7'd0,   8'd0}},
        '{FUNC_FREE,  3'd2, 7'd42,  1'b1, '{STATUS_NOT_BUSY, 3'd2, 7'd42,  8'd0}},
        '{FUNC_FREE,  3'd0, 7'd0,   1'b1, '{STATUS_OK,       3'd0, 7'd0,   8'd2}},
        '{FUNC_FREE,  3'd0, 7'd0,   1'b1, '{STATUS_NOT_BUSY, 3'd0, 7'd0,   8'd2}},
        '{FUNC_ALLOC, 3'd2, 7'd42,  1'b0, '0},
        '{FUNC_ALLOC, 3'd0, 7'd0,   1'b0, '0},
        '{FUNC_FREE,  3'd0, 7'd2,   1'b0, '0},
        '{FUNC_FREE,  3'd0, 7'd3,   1'b0, '0},
        '{FUNC_ALLOC, 3'd1, 7'd64,  1'b0, '0},
        '{FUNC_ALLOC, 3'd6, 7'd21,  1'b0, '0},
        '{FUNC_FREE,  3'd0, 7'd0,   1'b0, '0},
        '{FUNC_FREE,  3'd0, 7'd1,   1'b0, '0},
        '{FUNC_FREE,  3'd0, 7'd2,   1'b0, '0},
        '{FUNC_FREE,  3'd0, 7'd3,   1'b0, '0}
    };

    pooled_slot_allocator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .func      (func),
        .page_in   (page_in),
        .slot_in   (slot_in),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .page_out  (page_out),
        .slot_out  (slot_out),
        .page_used (page_used)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Overall time limit
    initial
    begin
        #20_000_000;
        $display("pooled_slot_allocator_unit: mismatch");
        $finish;
    end

    // One line per mismatch, printing capped
    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < 40)
            $display("%0t: %s got %0d, want %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Apply one request to the predicted pool and return the reply it yields
    function automatic slot_reply_t pool_apply(input logic [FUNC_W-1:0] f,
                                               input logic [PAGE_W-1:0] pg,
                                               input logic [SLOT_W-1:0] sl);
        slot_reply_t r;
        logic        searched;
        r = '0;
        r.status = STATUS_FULL;
        searched = 1'b0;
        if (f == FUNC_ALLOC)
        begin
            // first page with room decides; lowest free slot at or above its hint
            for (int p = 0; p < PAGES; p++)
            begin
                if (!searched && pool_count[p] < SLOTS)
                begin
                    searched = 1'b1;
                    for (int s = 0; s < SLOTS; s++)
                    begin
                        if (r.status == STATUS_FULL && s >= pool_hint[p] && !pool_busy[p][s])
                        begin
                            pool_busy[p][s] = 1'b1;
                            pool_count[p]++;
                            pool_total++;
                            pool_hint[p] = s + 1;
                            r.status = STATUS_OK;
                            r.page   = p[PAGE_W-1:0];
                            r.slot   = s[SLOT_W-1:0];
                            r.used   = pool_count[p][USED_W-1:0];
                        end
                    end
                end
            end
        end
        else
        begin
            // page and slot fields cannot leave the pool at this size
            r.page = pg;
            r.slot = sl;
            if (!pool_busy[pg][sl])
            begin
                r.status = STATUS_NOT_BUSY;
            end
            else
            begin
                pool_busy[pg][sl] = 1'b0;
                if (pool_count[pg] > 0)
                begin
                    pool_count[pg]--;
                    pool_total--;
                end
                if (pool_hint[pg] > sl)
                    pool_hint[pg] = 32'(sl);
                r.status = STATUS_OK;
            end
            r.used = pool_count[pg][USED_W-1:0];
        end
        return r;
    endfunction

    // Find a busy slot from a random starting point; 0 if the pool is empty
    function automatic bit pick_busy(output logic [PAGE_W-1:0] pg,
                                     output logic [SLOT_W-1:0] sl);
        int start;
        int idx;
        bit found;
        start = $urandom_range(0, PAGES * SLOTS - 1);
        found = 1'b0;
        pg = '0;
        sl = '0;
        for (int k = 0; k < PAGES * SLOTS; k++)
        begin
            idx = (start + k) % (PAGES * SLOTS);
            if (!found && pool_busy[idx / SLOTS][idx % SLOTS])
            begin
                found = 1'b1;
                pg = PAGE_W'(idx / SLOTS);
                sl = SLOT_W'(idx % SLOTS);
            end
        end
        return found;
    endfunction

    // Sender gap: mostly none or short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 80) return $urandom_range(1, 2);
        if (r < 95) return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // Drive one request and hold it until accepted, then record its reply
    task automatic issue_request(input logic [FUNC_W-1:0] f, input logic [PAGE_W-1:0] pg,
                                 input logic [SLOT_W-1:0] sl, input logic typed,
                                 input slot_reply_t typed_want);
        slot_reply_t want;
        req_valid <= 1'b1;
        func      <= f;
        page_in   <= pg;
        slot_in   <= sl;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        want = pool_apply(f, pg, sl);
        owed_results.push_back(typed ? typed_want : want);
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0)
        begin
            req_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Hold off until every reply has come back
    task automatic drain_replies();
        req_valid <= 1'b0;
        @(posedge clk);
        while (owed_results.size() != 0)
            @(posedge clk);
    endtask

    // One random item: allocate, free a busy slot, or free any handle
    task automatic random_item(input int alloc_pct, input int busy_pct);
        int                r;
        logic [PAGE_W-1:0] pg;
        logic [SLOT_W-1:0] sl;
        r = $urandom_range(0, 99);
        if (r < alloc_pct)
            issue_request(FUNC_ALLOC, PAGE_W'($urandom_range(0, 7)),
                          SLOT_W'($urandom_range(0, 127)), 1'b0, '0);
        else if (r < alloc_pct + busy_pct && pick_busy(pg, sl))
            issue_request(FUNC_FREE, pg, sl, 1'b0, '0);
        else
            issue_request(FUNC_FREE, PAGE_W'($urandom_range(0, 7)),
                          SLOT_W'($urandom_range(0, 127)), 1'b0, '0);
        pause_sender(gap_len());
    endtask

    // Receiver: stall bursts of random length between runs, some runs long
    initial
    begin
        int r;
        int run;
        int hold;
        @(posedge rst_n);
        forever
        begin
            r = $urandom_range(0, 99);
            run = (r < 15) ? $urandom_range(50, 200) : $urandom_range(1, 8);
            repeat (run) @(posedge clk);
            r = $urandom_range(0, 99);
            if (r < 60) hold = $urandom_range(1, 2);
            else if (r < 90) hold = $urandom_range(3, 6);
            else if (r < 98) hold = $urandom_range(7, 15);
            else hold = $urandom_range(30, 80);
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clk);
            rsp_stall <= 1'b0;
        end
    end

    // Reply checker
    always @(posedge clk)
    begin
        slot_reply_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (owed_results.size() == 0)
            begin
                report_mismatch("reply with none owed, status", int'(status), 0);
            end
            else
            begin
                want = owed_results.pop_front();
                if (status !== want.status)
                    report_mismatch("status", int'(status), int'(want.status));
                if (page_out !== want.page)
                    report_mismatch("page_out", int'(page_out), int'(want.page));
                if (slot_out !== want.slot)
                    report_mismatch("slot_out", int'(slot_out), int'(want.slot));
                if (page_used !== want.used)
                    report_mismatch("page_used", int'(page_used), int'(want.used));
            end
        end
    end

    // Main sequence
    initial
    begin
        int waited;
        for (int p = 0; p < PAGES; p++)
        begin
            pool_busy[p]  = '0;
            pool_count[p] = 0;
            pool_hint[p]  = 0;
        end
        pool_total = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed rows
        for (int i = 0; i < ROWS; i++)
        begin
            issue_request(pool_rows[i].func, pool_rows[i].page, pool_rows[i].slot,
                          pool_rows[i].typed, pool_rows[i].want);
            pause_sender(gap_len());
        end
        drain_replies();

        // mixed traffic on a sparse pool
        repeat (60) random_item(55, 35);

        // fill the whole pool, then churn while it is full
        while (pool_total < PAGES * SLOTS)
            random_item(98, 1);
        repeat (40) random_item(50, 40);
        drain_replies();

        // release some of what is held
        repeat (60) random_item(20, 70);

        // wait out the remaining replies
        req_valid <= 1'b0;
        waited = 0;
        while (owed_results.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (owed_results.size() != 0)
            report_mismatch("replies never returned", owed_results.size(), 0);
        if (mismatches == 0)
            $display("pooled_slot_allocator_unit: match");
        else
            $display("pooled_slot_allocator_unit: mismatch");
        $finish;
    end

endmodule
